// ----- rtl/utxf_pkg.sv -----
// Types and constants shared by the UART transmitter with its byte buffer.
`timescale 1ns / 1ps

package utxf_pkg;

	localparam int BUFFER_DEPTH_LOG2 = 4;
	localparam int BUF_DEPTH = 1 << BUFFER_DEPTH_LOG2;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [3:0] BITS_PER_CHAR = 4'd8;

	typedef logic [BUFFER_DEPTH_LOG2-1:0] ptr_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_START = 4'b0010,
		PH_DATA  = 4'b0100,
		PH_STOP  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic       tx_level;
		logic       accepted;
		logic       buffer_full;
		logic       line_busy;
		logic       timer_restart;
	} result_t;

	typedef struct packed {
		logic       is_tick;
		logic [7:0] data_byte;
	} cmd_t;

endpackage

// ----- rtl/uart_tx_with_fifo_top.sv -----
// Top level of the 8N1 UART transmitter with its byte buffer.
`timescale 1ns / 1ps

// Each item is either a byte push or one bit-period tick, and each gives exactly one
// result. The block takes one item per cycle unless item_stall is high: a two-entry
// command queue feeds the transmit engine, which handles one command per cycle while
// its result register is empty or being read out, and registers its result. Each item
// passes through the command queue, and its result is held in the engine's result
// register until taken. The byte buffer has 2^BUFFER_DEPTH_LOG2 entries and holds one
// fewer; a push into a full buffer is dropped and reported with accepted low. No clearing pass follows reset.
module uart_tx_with_fifo_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  utxf_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output utxf_pkg::result_t  result
);

	logic           cmd_valid;
	logic           cmd_stall;
	utxf_pkg::cmd_t cmd;

	utxf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd)
	);

	utxf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- rtl/utxf_front.sv -----
// Input side: classifies incoming items and holds them in a two-entry command queue.
`timescale 1ns / 1ps

module utxf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  utxf_pkg::item_t  item,
	output logic             cmd_valid,
	input  logic             cmd_stall,
	output utxf_pkg::cmd_t   cmd
);

	utxf_pkg::cmd_t ent_q [2];
	logic           wr_idx_q;
	logic           rd_idx_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;
	utxf_pkg::cmd_t in_cmd;

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign cmd_valid  = (cnt_q != 2'd0);
	assign pop        = cmd_valid && !cmd_stall;
	assign cmd        = ent_q[rd_idx_q];

	always_comb begin
		in_cmd.is_tick   = (item.func == utxf_pkg::FUNC_TICK);
		in_cmd.data_byte = item.data_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_idx_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= 1'b0;
			rd_idx_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_idx_q <= !wr_idx_q;
			end
			if (pop) begin
				rd_idx_q <= !rd_idx_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/utxf_back.sv -----
// Transmit engine: byte buffer, bit phase sequencer and result register.
`timescale 1ns / 1ps

module utxf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  utxf_pkg::cmd_t     cmd,
	output logic               result_valid,
	input  logic               result_stall,
	output utxf_pkg::result_t  result
);

	logic [7:0]         mem [utxf_pkg::BUF_DEPTH];
	logic [7:0]         rd_data_q;

	utxf_pkg::phase_t   phase_q, phase_d;
	logic [3:0]         bits_q, bits_d;
	logic [7:0]         shift_q, shift_d;
	logic               level_q, level_d;
	utxf_pkg::ptr_t     rp_q, rp_d;
	utxf_pkg::ptr_t     wp_q, wp_d;
	utxf_pkg::ptr_t     wp_inc;
	logic               we;
	logic               acc;
	logic               restart;
	logic               fire;
	logic               res_valid_q;
	utxf_pkg::result_t  res_q;

	assign fire         = cmd_valid && (!res_valid_q || !result_stall);
	assign cmd_stall    = !fire;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign wp_inc       = wp_q + utxf_pkg::ptr_t'(1);

	always_comb begin
		phase_d = phase_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		level_d = level_q;
		rp_d    = rp_q;
		wp_d    = wp_q;
		we      = 1'b0;
		acc     = 1'b0;
		restart = 1'b0;
		if (fire) begin
			if (cmd.is_tick) begin
				case (phase_q)
					utxf_pkg::PH_START: begin
						level_d = 1'b0;
						phase_d = utxf_pkg::PH_DATA;
						bits_d  = utxf_pkg::BITS_PER_CHAR;
						shift_d = rd_data_q;
						rp_d    = rp_q + utxf_pkg::ptr_t'(1);
					end
					utxf_pkg::PH_DATA: begin
						level_d = shift_q[0];
						shift_d = {1'b0, shift_q[7:1]};
						bits_d  = bits_q - 4'd1;
						if (bits_q == 4'd1) begin
							phase_d = utxf_pkg::PH_STOP;
						end
					end
					utxf_pkg::PH_STOP: begin
						level_d = 1'b1;
						phase_d = (rp_q != wp_q) ? utxf_pkg::PH_START : utxf_pkg::PH_IDLE;
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end else if (wp_inc != rp_q) begin
				we   = 1'b1;
				wp_d = wp_inc;
				acc  = 1'b1;
				if (phase_q == utxf_pkg::PH_IDLE) begin
					phase_d = utxf_pkg::PH_START;
					restart = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wp_q] <= cmd.data_byte;
		end
		if (we && (wp_q == rp_d)) begin
			rd_data_q <= cmd.data_byte;
		end else begin
			rd_data_q <= mem[rp_d];
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.tx_level      <= level_d;
			res_q.accepted      <= acc;
			res_q.buffer_full   <= ((wp_d + utxf_pkg::ptr_t'(1)) == rp_d);
			res_q.line_busy     <= (phase_d != utxf_pkg::PH_IDLE);
			res_q.timer_restart <= restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= utxf_pkg::PH_IDLE;
			bits_q      <= 4'd0;
			shift_q     <= 8'd0;
			level_q     <= 1'b1;
			rp_q        <= '0;
			wp_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			level_q <= level_d;
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
